@@ design/wcs_pkg.sv @@
package wcs_pkg;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSL     = 8'h5C;
  localparam logic [7:0] CH_LOWER_H = 8'h68;
  localparam logic [7:0] CH_LOWER_V = 8'h76;
  localparam logic [7:0] HELD_RESET = 8'h7E;

  typedef enum logic [5:0] {
    ST_OUT   = 6'b000001,
    ST_DASH  = 6'b000010,
    ST_SPACE = 6'b000100,
    ST_BSL   = 6'b001000,
    ST_SLASH = 6'b010000,
    ST_COMM  = 6'b100000
  } scan_state_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_LINE  = 2'd2
  } comment_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } out_t;

  // results of one request: first, optional second
  typedef struct packed {
    out_t first;
    out_t second;
    logic two;
  } step_res_t;

endpackage

@@ design/wcs_core.sv @@
module wcs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              code_mode,
  input  wcs_pkg::in_t      req,
  output wcs_pkg::step_res_t res
);
  import wcs_pkg::*;

  scan_state_t   state_r, state_nxt;
  comment_kind_t kind_r, kind_nxt;
  logic [7:0]    held_r, held_nxt;

  logic [7:0] ch;
  logic [7:0] prior;
  logic       closes;
  logic [7:0] e0, e1;
  logic [1:0] n;

  assign ch = req.in_byte;

  always_comb begin
    prior = (kind_r == KIND_LINE) ? CH_SPACE : held_r;
    case (kind_r)
      KIND_LINE:  closes = (ch == CH_LF);
      KIND_BLOCK: closes = (prior == CH_STAR) && (ch == CH_SLASH);
      default:    closes = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    held_nxt  = (ch != CH_SPACE) ? ch : prior;
    e0 = 8'h00;
    e1 = 8'h00;
    n  = 2'd0;
    case (state_r)
      ST_DASH: begin
        if (ch != CH_LOWER_V && ch != CH_LOWER_H) begin
          e0 = CH_DASH; e1 = ch; n = 2'd2;
          state_nxt = ST_OUT;
        end
      end
      ST_SPACE: begin
        if (code_mode && ch == CH_LF) begin
          e0 = CH_SPACE; n = 2'd1;
        end else if (ch != CH_SPACE) begin
          e0 = CH_SPACE; e1 = ch; n = 2'd2;
          state_nxt = ST_OUT;
        end
      end
      ST_BSL: begin
        if (ch != CH_LF) begin
          e0 = CH_BSL; e1 = ch; n = 2'd2;
          state_nxt = ST_OUT;
        end
      end
      ST_SLASH: begin
        if (ch == CH_STAR) begin
          state_nxt = ST_COMM;
          kind_nxt  = KIND_BLOCK;
        end else if (ch == CH_SLASH) begin
          state_nxt = ST_COMM;
          kind_nxt  = KIND_LINE;
        end else begin
          e0 = CH_SLASH; e1 = ch; n = 2'd2;
          state_nxt = ST_OUT;
        end
      end
      ST_COMM: begin
        if (closes) begin
          state_nxt = ST_OUT;
        end
      end
      default: begin
        state_nxt = ST_OUT;
        if (ch == CH_TAB) begin
          n = 2'd0;
        end else if (ch == CH_CR) begin
          if (!code_mode) begin
            e0 = ch; n = 2'd1;
          end
        end else if (ch == CH_LF) begin
          e0 = code_mode ? CH_SPACE : ch; n = 2'd1;
        end else if (ch == CH_SPACE) begin
          state_nxt = ST_SPACE;
        end else if (ch == CH_DASH) begin
          if (code_mode) begin
            e0 = ch; n = 2'd1;
          end else begin
            state_nxt = ST_DASH;
          end
        end else if (ch == CH_BSL) begin
          state_nxt = ST_BSL;
        end else if (ch == CH_SLASH) begin
          if (code_mode) begin
            state_nxt = ST_SLASH;
          end
        end else begin
          e0 = ch; n = 2'd1;
        end
      end
    endcase
    if (req.string_last) begin
      state_nxt = ST_OUT;
      kind_nxt  = KIND_NONE;
      held_nxt  = HELD_RESET;
    end
  end

  always_comb begin
    res.two               = (n == 2'd2);
    res.first.out_byte    = e0;
    res.first.byte_valid  = (n != 2'd0);
    res.first.run_last    = (n != 2'd2);
    res.first.string_end  = (n != 2'd2) && req.string_last;
    res.second.out_byte   = e1;
    res.second.byte_valid = 1'b1;
    res.second.run_last   = 1'b1;
    res.second.string_end = req.string_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_OUT;
      kind_r  <= KIND_NONE;
      held_r  <= HELD_RESET;
    end else if (step_en) begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      held_r  <= held_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && req.string_last |=>
      state_r == ST_OUT && kind_r == KIND_NONE && held_r == HELD_RESET)
    else $error("state not cleared after string end");

  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.two |-> res.first.byte_valid && !res.first.run_last)
    else $error("malformed result pair");

  a_comment_kind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COMM |-> kind_r != KIND_NONE)
    else $error("comment state without comment kind");
`endif

endmodule

@@ design/whitespace_comment_squeezer_unit.sv @@
// channel  | dir | handshake          | payload
// in_      | in  | in_valid/in_stall  | in_data   (wcs_pkg::in_t)
// out_     | out | out_valid/out_stall| out_data  (wcs_pkg::out_t)
// cfg_     | in  | cfg_valid/cfg_ready| cfg_data  (code_mode)
//
// A request is processed in the cycle it is accepted; its results wait in a
// two-entry output register. One request per cycle if out_stall is low and
// each yields one result; one yielding two holds the next until its second
// result leaves (one leaves per cycle unless stalled). Reset (rst_n low,
// synchronous) clears scan state, mode and the output register. in_stall is
// high while results remain that do not leave in the current cycle.
module whitespace_comment_squeezer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wcs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wcs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);
  import wcs_pkg::*;

  logic      code_mode_r;
  out_t      slot0_r, slot1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic      in_acc, out_pop;
  step_res_t res;

  assign cfg_ready = 1'b1;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 2'd0) || (cnt_r == 2'd1 && out_pop));
  assign in_acc    = in_valid && !in_stall;

  wcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .code_mode (code_mode_r),
    .req       (in_data),
    .res       (res)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = res.two ? 2'd2 : 2'd1;
    end else if (out_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_mode_r <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        code_mode_r <= cfg_data;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot0_r <= res.first;
      slot1_r <= res.second;
    end else if (out_pop) begin
      slot0_r <= slot1_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output register overfilled");

  a_pair_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res.two |=> cnt_r == 2'd2 && !slot0_r.run_last && slot1_r.run_last)
    else $error("result pair not queued in order");

  a_head_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !slot0_r.run_last && !slot0_r.string_end)
    else $error("first of two results marked last");

  a_drain_single: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc && out_pop && cnt_r == 2'd2 |=> cnt_r == 2'd1 && slot0_r.run_last)
    else $error("second result lost on drain");
`endif

endmodule
